// ----- src/rtc_pkg.sv -----
// Shared types and constants for the real-time clock with alarm.
package rtc_pkg;

   localparam int OFFSET_W = 10;
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_READ  = 2'd1,
      ACT_WRITE = 2'd2
   } action_type;

   // Register word offsets
   localparam logic [OFFSET_W-1:0] W_ID      = 10'd0;
   localparam logic [OFFSET_W-1:0] W_CNTR    = 10'd4;
   localparam logic [OFFSET_W-1:0] W_ALARM   = 10'd5;
   localparam logic [OFFSET_W-1:0] W_CTRL    = 10'd6;
   localparam logic [OFFSET_W-1:0] W_ST      = 10'd7;
   localparam logic [OFFSET_W-1:0] W_SEC_CFG = 10'd9;

   localparam logic [DATA_W-1:0] ID_VALUE      = 32'h0301_1006;
   localparam logic [DATA_W-1:0] SEC_CFG_RESET = 32'h0000_3fff;

   localparam int CTRL_EN_BIT    = 0;
   localparam int CTRL_INT_BIT   = 2;
   localparam int ST_ALM_BIT     = 2;
   localparam int ST_WR_DONE_BIT = 16;

   localparam logic [6:0] SEC_WRAP  = 7'd60;
   localparam logic [6:0] MIN_WRAP  = 7'd60;
   localparam logic [5:0] HOUR_WRAP = 6'd24;

   typedef struct packed {
      logic [DATA_W-1:0] time_value;
      logic              alarm_match;
   } tick_result_type;

endpackage

// ----- src/rtc_time_of_day_alarm.sv -----
// Top level of the real-time clock with alarm: request stage, register file, response stage.
// Each transaction (one-second tick, register read or register write) is taken into a request
// register, executed against the register file once the response register is free or draining,
// and its result is written into the response register as it executes. One transaction per
// cycle is sustained while rsp_ready stays high; the single register-file update per cycle
// sets that rate, and each transaction sees every state change made by the one before it.
// rsp_irq_pending reports the interrupt level after the transaction. Offsets at or beyond
// REG_WORDS read as zero and ignore writes. No clearing pass is needed after reset.
module rtc_time_of_day_alarm #(
   parameter int REG_WORDS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic [rtc_pkg::OFFSET_W-1:0]  req_word_offset,
   input  logic [rtc_pkg::DATA_W-1:0]    req_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rtc_pkg::DATA_W-1:0]    rsp_read_data,
   output logic                          rsp_irq_pending
);

   logic                          s1_valid_ff;
   logic [1:0]                    s1_action_ff;
   logic [rtc_pkg::OFFSET_W-1:0]  s1_offset_ff;
   logic [rtc_pkg::DATA_W-1:0]    s1_wdata_ff;
   logic                          s1_go;

   logic                          rsp_valid_ff;
   logic [rtc_pkg::DATA_W-1:0]    rsp_data_ff;
   logic                          rsp_irq_ff;

   logic [rtc_pkg::DATA_W-1:0]    read_data;
   logic                          irq_next;

   // request stage moves on when the response register is free or draining
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_action_ff <= req_action;
         s1_offset_ff <= req_word_offset;
         s1_wdata_ff  <= req_write_data;
      end
   end

   rtc_regs #(
      .REG_WORDS (REG_WORDS)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .step_en     (s1_go),
      .action      (s1_action_ff),
      .word_offset (s1_offset_ff),
      .write_data  (s1_wdata_ff),
      .read_data   (read_data),
      .irq_next    (irq_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff <= read_data;
         rsp_irq_ff  <= irq_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_irq_pending = rsp_irq_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request stage stalled without a blocked response");

   a_execute_gives_response: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid_ff)
      else $error("executed transaction produced no response");

   a_rsp_holds_while_waiting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready
      |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq_pending))
      else $error("response changed while waiting for ready");

endmodule

// ----- src/rtc_tick.sv -----
// Time counter increment with carry chain and alarm compare.
module rtc_tick (
   input  logic [rtc_pkg::DATA_W-1:0] time_cur,
   input  logic [rtc_pkg::DATA_W-1:0] alarm_word,
   output rtc_pkg::tick_result_type   result
);

   logic [5:0]  sec;
   logic [5:0]  min;
   logic [4:0]  hour;
   logic [14:0] day;
   logic [6:0]  sec_inc;
   logic [6:0]  min_inc;
   logic [5:0]  hour_inc;
   logic [5:0]  sec_new;
   logic [5:0]  min_new;
   logic [4:0]  hour_new;
   logic [14:0] day_new;

   always_comb begin
      sec      = time_cur[5:0];
      min      = time_cur[11:6];
      hour     = time_cur[16:12];
      day      = time_cur[31:17];
      sec_inc  = {1'b0, sec} + 7'd1;
      min_inc  = {1'b0, min} + 7'd1;
      hour_inc = {1'b0, hour} + 6'd1;

      sec_new  = sec_inc[5:0];
      min_new  = min;
      hour_new = hour;
      day_new  = day;
      if (sec_inc >= rtc_pkg::SEC_WRAP) begin
         sec_new = '0;
         min_new = min_inc[5:0];
         if (min_inc >= rtc_pkg::MIN_WRAP) begin
            min_new  = '0;
            hour_new = hour_inc[4:0];
            if (hour_inc >= rtc_pkg::HOUR_WRAP) begin
               hour_new = '0;
               day_new  = day + 15'd1;
            end
         end
      end

      result.time_value  = {day_new, hour_new, min_new, sec_new};
      result.alarm_match = (sec_new == alarm_word[5:0]) &&
                           (min_new == alarm_word[11:6]) &&
                           (hour_new == alarm_word[16:12]);
   end

endmodule

// ----- src/rtc_regs.sv -----
// Register file: time counter, alarm, control, alarm flag and plain words.
module rtc_regs #(
   parameter int REG_WORDS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [1:0]                    action,
   input  logic [rtc_pkg::OFFSET_W-1:0]  word_offset,
   input  logic [rtc_pkg::DATA_W-1:0]    write_data,
   output logic [rtc_pkg::DATA_W-1:0]    read_data,
   output logic                          irq_next
);

   localparam int IDX_W = $clog2(REG_WORDS);

   logic [rtc_pkg::DATA_W-1:0] time_ff, time_in;
   logic [rtc_pkg::DATA_W-1:0] alarm_ff, alarm_in;
   logic [rtc_pkg::DATA_W-1:0] ctrl_ff, ctrl_in;
   logic                       flag_ff, flag_in;
   logic [rtc_pkg::DATA_W-1:0] plain_ff [REG_WORDS];

   logic [IDX_W-1:0]           idx;
   logic                       in_range;
   logic                       plain_we;
   rtc_pkg::tick_result_type   tick_res;

   rtc_tick u_tick (
      .time_cur   (time_ff),
      .alarm_word (alarm_ff),
      .result     (tick_res)
   );

   assign idx      = word_offset[IDX_W-1:0];
   assign in_range = word_offset < rtc_pkg::OFFSET_W'(REG_WORDS);

   always_comb begin
      time_in   = time_ff;
      alarm_in  = alarm_ff;
      ctrl_in   = ctrl_ff;
      flag_in   = flag_ff;
      plain_we  = 1'b0;
      read_data = '0;
      unique case (action)
         rtc_pkg::ACT_TICK: begin
            if (ctrl_ff[rtc_pkg::CTRL_EN_BIT]) begin
               time_in = tick_res.time_value;
               if (tick_res.alarm_match) begin
                  flag_in = 1'b1;
               end
            end
         end
         rtc_pkg::ACT_READ: begin
            unique case (word_offset)
               rtc_pkg::W_ID:    read_data = rtc_pkg::ID_VALUE;
               rtc_pkg::W_CNTR:  read_data = time_ff;
               rtc_pkg::W_ALARM: read_data = alarm_ff;
               rtc_pkg::W_CTRL:  read_data = ctrl_ff;
               rtc_pkg::W_ST: begin
                  read_data[rtc_pkg::ST_WR_DONE_BIT] = 1'b1;
                  read_data[rtc_pkg::ST_ALM_BIT]     = flag_ff;
               end
               default: begin
                  if (in_range) begin
                     read_data = plain_ff[idx];
                  end
               end
            endcase
         end
         rtc_pkg::ACT_WRITE: begin
            unique case (word_offset)
               rtc_pkg::W_CNTR:  time_in  = write_data;
               rtc_pkg::W_ALARM: alarm_in = write_data;
               rtc_pkg::W_CTRL:  ctrl_in  = write_data;
               rtc_pkg::W_ST: begin
                  if (write_data[rtc_pkg::ST_ALM_BIT]) begin
                     flag_in = 1'b0;
                  end
               end
               // identifier word writes land in plain storage
               default:          plain_we = in_range;
            endcase
         end
         default: ;
      endcase
      irq_next = flag_in & ctrl_in[rtc_pkg::CTRL_INT_BIT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= '0;
         alarm_ff <= '0;
         ctrl_ff  <= '0;
         flag_ff  <= 1'b0;
      end else if (step_en) begin
         time_ff  <= time_in;
         alarm_ff <= alarm_in;
         ctrl_ff  <= ctrl_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_WORDS; i++) begin
            plain_ff[i] <= (i == int'(rtc_pkg::W_SEC_CFG)) ? rtc_pkg::SEC_CFG_RESET : '0;
         end
      end else if (step_en && plain_we) begin
         plain_ff[idx] <= write_data;
      end
   end

   a_tick_disabled_holds: assert property (@(posedge clock) disable iff (reset)
      step_en && action == rtc_pkg::ACT_TICK && !ctrl_ff[rtc_pkg::CTRL_EN_BIT]
      |=> $stable(time_ff))
      else $error("time counter moved on a disabled tick");

   a_seconds_in_range: assert property (@(posedge clock) disable iff (reset)
      step_en && action == rtc_pkg::ACT_TICK && ctrl_ff[rtc_pkg::CTRL_EN_BIT]
      |=> {1'b0, time_ff[5:0]} < rtc_pkg::SEC_WRAP)
      else $error("seconds field out of range after a counted tick");

   a_status_clears_flag: assert property (@(posedge clock) disable iff (reset)
      step_en && action == rtc_pkg::ACT_WRITE && word_offset == rtc_pkg::W_ST &&
      write_data[rtc_pkg::ST_ALM_BIT]
      |=> !flag_ff)
      else $error("alarm flag not cleared by status write");

endmodule
